// ----- sv/logodds_pkg.sv -----
// Shared types, codes and constants for the log-odds occupancy grid block.
// No dependencies; used by the top level and the testbench.
`default_nettype none

package logodds_pkg;

	localparam int GRID_WIDTH_DEF  = 1024;
	localparam int GRID_HEIGHT_DEF = 1024;
	localparam int COUNT_BITS_DEF  = 8;

	localparam int LO_W = 15;
	localparam int QUO_W = 11;
	localparam logic signed [15:0] LO_STEP  = 16'sd1735;
	localparam logic signed [15:0] LO_LIMIT = 16'sd10240;

	localparam logic [2:0] CFG_POSE_X  = 3'd0;
	localparam logic [2:0] CFG_POSE_Y  = 3'd1;
	localparam logic [2:0] CFG_SIN     = 3'd2;
	localparam logic [2:0] CFG_COS     = 3'd3;
	localparam logic [2:0] CFG_INV_RES = 3'd4;

	localparam logic signed [15:0] COS_RESET     = 16'sd16384;
	localparam logic [15:0]        INV_RES_RESET = 16'd1092;

	typedef enum logic [1:0] {
		CMD_FREE   = 2'd0,
		CMD_OCC    = 2'd1,
		CMD_COMMIT = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		CLASS_FREE    = 2'd0,
		CLASS_OCC     = 2'd1,
		CLASS_UNKNOWN = 2'd2
	} class_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_SCALE,
		ST_MAP,
		ST_READ,
		ST_MODIFY,
		ST_DIV,
		ST_APPLY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [15:0] point_lateral_mm;
		logic signed [15:0] point_forward_mm;
		logic [19:0]        commit_cell;
	} req_t;

	typedef struct packed {
		logic [19:0] cell_index;
		logic        in_bounds;
		logic [1:0]  cell_class;
	} res_t;

	function automatic class_t classify(input logic signed [15:0] lo);
		class_t c;
		if (lo > LO_STEP) begin
			c = CLASS_OCC;
		end else if (lo < -LO_STEP) begin
			c = CLASS_FREE;
		end else begin
			c = CLASS_UNKNOWN;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- sv/log_odds_occupancy_grid_update_top.sv -----
// Log-odds occupancy grid update: point binning, commit with log-odds step and class.
// Depends on logodds_pkg and logodds_ram.
`default_nettype none

// After reset the block sweeps the cell store to zero, one cell per cycle;
// req_ready stays low during that pass while configuration writes are taken.
// Items are then handled one at a time. A point item passes through three
// arithmetic stages for rotation, pose add and scaling, one for the cell index,
// the read and write-back of the cell through the store's single ports, then the
// result load; a point that falls off the grid skips the read and write-back. A
// commit reads the cell and, when the cell has hits, takes the log-odds step from
// an 11-bit restoring divider and writes the cell back with cleared counts. An
// out-of-range commit or command three goes straight to the result load. The
// result load waits while the output register holds an untaken result, and the
// block returns to idle as the result is loaded. The result sits in an output
// register, so a new request is taken while the previous result waits.
module log_odds_occupancy_grid_update_top import logodds_pkg::*; #(
	parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output      logic        req_ready,
	input  wire req_t        req,
	output      logic        res_valid,
	input  wire logic        res_ready,
	output      res_t        res,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	localparam int unsigned CELLS = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW = $clog2(CELLS);
	localparam int CB = COUNT_BITS;
	localparam int DW = LO_W + 2 * CB;
	localparam int NW = CB + 13;
	localparam logic signed [27:0] HALF_W = 28'(GRID_WIDTH / 2);
	localparam logic signed [27:0] HALF_H = 28'(GRID_HEIGHT / 2);
	localparam logic signed [27:0] W_S = 28'(GRID_WIDTH);
	localparam logic signed [27:0] H_S = 28'(GRID_HEIGHT);
	localparam logic [CB-1:0] CNT_MAX = '1;

	state_t state_q, state_d;

	logic signed [23:0] pose_x_q, pose_y_q;
	logic signed [15:0] sin_q, cos_q;
	logic [15:0]        inv_q;

	logic [1:0]         cmd_q;
	logic signed [15:0] lat_q, fwd_q;
	logic signed [31:0] p_ls_s1, p_fc_s1, p_fs_s1, p_lc_s1;
	logic signed [39:0] gx_s2, gy_s2;
	logic [25:0]        qx_s3, qy_s3;
	logic               negx_s3, negy_s3;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      clr_q;

	logic [19:0] pend_idx_q;
	logic        pend_inb_q;
	class_t      pend_cls_q;
	res_t        res_q;
	logic        res_valid_q;

	logic signed [15:0] lo_q;
	logic               neg_q;
	logic [NW-1:0]      rem_q, dsh_q;
	logic [QUO_W-1:0]   quo_q;
	logic [3:0]         k_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata, ram_rdata;

	logic               accept;
	logic               commit_ok;
	logic [39:0]        magx, magy;
	logic [55:0]        scx, scy;
	logic signed [27:0] cx, cy;
	logic               pt_inb;
	logic [31:0]        pt_idx;
	logic signed [15:0] rd_lo;
	logic [CB-1:0]      rd_occ, rd_fre;
	logic [CB-1:0]      occ_inc, fre_inc;
	logic [CB:0]        den;
	logic [CB-1:0]      diff;
	logic [NW-1:0]      num;
	logic signed [16:0] lo_sum;
	logic signed [15:0] lo_new;
	logic               is_point;
	logic               res_free;

	logodds_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign accept    = req_valid && req_ready;
	assign commit_ok = 32'(req.commit_cell) < CELLS;
	assign is_point  = (cmd_q == CMD_FREE) || (cmd_q == CMD_OCC);
	assign res_free  = !res_valid_q || res_ready;

	// scaling: round magnitude, halves away from zero
	assign magx = gx_s2[39] ? 40'(-gx_s2) : 40'(gx_s2);
	assign magy = gy_s2[39] ? 40'(-gy_s2) : 40'(gy_s2);
	assign scx  = 56'(magx) * 56'(inv_q) + 56'(1) * (56'(1) << 29);
	assign scy  = 56'(magy) * 56'(inv_q) + 56'(1) * (56'(1) << 29);

	assign cx = (negx_s3 ? -$signed({2'b00, qx_s3}) : $signed({2'b00, qx_s3})) + HALF_W;
	assign cy = (negy_s3 ? -$signed({2'b00, qy_s3}) : $signed({2'b00, qy_s3})) + HALF_H;
	assign pt_inb = !cx[27] && (cx < W_S) && !cy[27] && (cy < H_S);
	assign pt_idx = 32'($unsigned(cy)) * 32'(GRID_WIDTH) + 32'($unsigned(cx));

	assign rd_lo   = 16'($signed(ram_rdata[DW-1 -: LO_W]));
	assign rd_occ  = ram_rdata[2*CB-1 -: CB];
	assign rd_fre  = ram_rdata[CB-1:0];
	assign occ_inc = (rd_occ == CNT_MAX) ? rd_occ : rd_occ + CB'(1);
	assign fre_inc = (rd_fre == CNT_MAX) ? rd_fre : rd_fre + CB'(1);
	assign den     = (CB+1)'(rd_occ) + (CB+1)'(rd_fre);
	assign diff    = (rd_fre > rd_occ) ? rd_fre - rd_occ : rd_occ - rd_fre;
	assign num     = NW'(diff) * NW'(LO_STEP);

	assign lo_sum = 17'(lo_q) + (neg_q ? -$signed({6'b0, quo_q}) : $signed({6'b0, quo_q}));
	always_comb begin
		if (lo_sum > 17'(LO_LIMIT)) begin
			lo_new = LO_LIMIT;
		end else if (lo_sum < -17'(LO_LIMIT)) begin
			lo_new = -LO_LIMIT;
		end else begin
			lo_new = 16'(lo_sum);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(CELLS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					priority if (req.cmd == CMD_FREE || req.cmd == CMD_OCC) begin
						state_d = ST_MUL;
					end else if (req.cmd == CMD_COMMIT && commit_ok) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_MUL:   state_d = ST_SUM;
			ST_SUM:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_MAP;
			ST_MAP:   state_d = pt_inb ? ST_READ : ST_DONE;
			ST_READ:  state_d = ST_MODIFY;
			ST_MODIFY: begin
				state_d = (is_point || den == '0) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (k_q == '0) state_d = ST_APPLY;
			end
			ST_APPLY: state_d = ST_DONE;
			ST_DONE: begin
				if (res_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// outputs and store control
	always_comb begin
		req_ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_IDLE: req_ready = 1'b1;
			ST_MODIFY: begin
				if (is_point) begin
					ram_we = 1'b1;
					if (cmd_q == CMD_OCC) begin
						ram_wdata = {rd_lo[LO_W-1:0], occ_inc, rd_fre};
					end else begin
						ram_wdata = {rd_lo[LO_W-1:0], rd_occ, fre_inc};
					end
				end
			end
			ST_APPLY: begin
				ram_we    = 1'b1;
				ram_wdata = {lo_new[LO_W-1:0], {(2*CB){1'b0}}};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			sin_q       <= '0;
			cos_q       <= COS_RESET;
			inv_q       <= INV_RES_RESET;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == ST_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_POSE_X:  pose_x_q <= cfg_data;
					CFG_POSE_Y:  pose_y_q <= cfg_data;
					CFG_SIN:     sin_q    <= cfg_data[15:0];
					CFG_COS:     cos_q    <= cfg_data[15:0];
					CFG_INV_RES: inv_q    <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q      <= req.cmd;
				lat_q      <= req.point_lateral_mm;
				fwd_q      <= req.point_forward_mm;
				idx_q      <= AW'(32'(req.commit_cell));
				pend_cls_q <= CLASS_UNKNOWN;
				if (req.cmd == CMD_COMMIT) begin
					pend_idx_q <= req.commit_cell;
					pend_inb_q <= commit_ok;
				end else begin
					pend_idx_q <= '0;
					pend_inb_q <= 1'b0;
				end
			end
			ST_MUL: begin
				p_ls_s1 <= lat_q * sin_q;
				p_fc_s1 <= fwd_q * cos_q;
				p_fs_s1 <= fwd_q * sin_q;
				p_lc_s1 <= lat_q * cos_q;
			end
			ST_SUM: begin
				gx_s2 <= (40'(pose_x_q) <<< 14) + 40'(p_ls_s1) + 40'(p_fc_s1);
				gy_s2 <= (40'(pose_y_q) <<< 14) + 40'(p_fs_s1) - 40'(p_lc_s1);
			end
			ST_SCALE: begin
				negx_s3 <= gx_s2[39];
				negy_s3 <= gy_s2[39];
			end
			ST_MAP: begin
				qx_s3 <= qx_s3;
				if (pt_inb) begin
					idx_q      <= AW'(pt_idx);
					pend_idx_q <= 20'(pt_idx);
					pend_inb_q <= 1'b1;
				end
			end
			ST_MODIFY: begin
				lo_q  <= rd_lo;
				neg_q <= rd_fre > rd_occ;
				rem_q <= {num[NW-2:0], 1'b0} + NW'(den);
				dsh_q <= NW'(den) << 11;
				quo_q <= '0;
				k_q   <= 4'(QUO_W - 1);
				if (!is_point) pend_cls_q <= classify(rd_lo);
			end
			ST_DIV: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
				k_q   <= k_q - 4'd1;
			end
			ST_APPLY: pend_cls_q <= classify(lo_new);
			ST_DONE: begin
				if (res_free) begin
					res_q.cell_index <= pend_idx_q;
					res_q.in_bounds  <= pend_inb_q;
					res_q.cell_class <= pend_cls_q;
				end
			end
			default: ;
		endcase
		// take rounded cell offsets in the same stage as the signs
		if (state_q == ST_SCALE) begin
			qx_s3 <= 26'(scx >> 30);
			qy_s3 <= 26'(scy >> 30);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !req_ready)
		else $error("request taken during clearing pass");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_CLEAR || state_q == ST_MODIFY || state_q == ST_APPLY)
		else $error("store written outside read-modify-write");

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_APPLY |-> quo_q <= QUO_W'(LO_STEP))
		else $error("log-odds step above limit");

	a_accept_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q != ST_IDLE)
		else $error("accepted request not processed");

endmodule

`default_nettype wire

// ----- sv/logodds_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module logodds_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- dv/log_odds_occupancy_grid_update_top_test.sv -----
// Self-checking testbench for log_odds_occupancy_grid_update_top: random and directed
// requests under several pose/yaw/resolution settings, checked against a cell-level predictor.
// Depends on logodds_pkg and the top level RTL.
`default_nettype none

module log_odds_occupancy_grid_update_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import logodds_pkg::*;

	localparam int GW = 1024;
	localparam int GH = 1024;
	localparam int CELLS = GW * GH;
	localparam int HIT_MAX = 255;
	localparam int CENTER = (GH / 2) * GW + GW / 2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_t        res;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = CFG_POSE_X;
	logic [23:0] cfg_data = '0;

	log_odds_occupancy_grid_update_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// grid model, sparse: absent entries are the cleared state
	shortint cell_lo[int];
	int      occ_hits[int];
	int      free_hits[int];
	longint  pose_x = 0, pose_y = 0, sin_q = 0, cos_q = 16384, inv_q = 1092;

	req_t    pending_reqs[$];
	res_t    expected_res[$];
	int      n_queued = 0, n_taken = 0, n_checked = 0, n_err = 0;
	int      n_commits = 0, n_inb = 0;
	bit      quiet = 0;
	bit      hold_req = 0;

	typedef struct {
		logic signed [15:0] lat;
		logic signed [15:0] fwd;
	} point_t;
	point_t  seen_points[$];
	int      hot_cells[$];

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint scale_to_cell(input longint p);
		longint m;
		m = (p < 0) ? -p : p;
		m = (m * inv_q + (longint'(1) <<< 29)) >>> 30;
		return (p < 0) ? -m : m;
	endfunction

	function automatic void locate_point(input logic signed [15:0] lat,
			input logic signed [15:0] fwd, output bit inb, output int idx);
		longint gx, gy, cx, cy;
		gx = pose_x * 16384 + longint'(lat) * sin_q + longint'(fwd) * cos_q;
		gy = pose_y * 16384 + longint'(fwd) * sin_q - longint'(lat) * cos_q;
		cx = scale_to_cell(gx) + GW / 2;
		cy = scale_to_cell(gy) + GH / 2;
		inb = (cx >= 0 && cx < GW && cy >= 0 && cy < GH);
		idx = inb ? int'(cy * GW + cx) : 0;
	endfunction

	function automatic res_t update_grid(input req_t r);
		res_t   o;
		bit     inb;
		int     idx, lo, occ, fre, den, diff, q;
		o.cell_index = '0;
		o.in_bounds = 1'b0;
		o.cell_class = CLASS_UNKNOWN;
		if (r.cmd == CMD_FREE || r.cmd == CMD_OCC) begin
			locate_point(r.point_lateral_mm, r.point_forward_mm, inb, idx);
			if (inb) begin
				if (r.cmd == CMD_OCC) begin
					occ = occ_hits.exists(idx) ? occ_hits[idx] : 0;
					if (occ < HIT_MAX) occ_hits[idx] = occ + 1;
				end else begin
					fre = free_hits.exists(idx) ? free_hits[idx] : 0;
					if (fre < HIT_MAX) free_hits[idx] = fre + 1;
				end
				o.cell_index = idx[19:0];
				o.in_bounds = 1'b1;
			end
		end else if (r.cmd == CMD_COMMIT) begin
			idx = int'(r.commit_cell);
			o.cell_index = r.commit_cell;
			if (idx < CELLS) begin
				lo = cell_lo.exists(idx) ? cell_lo[idx] : 0;
				occ = occ_hits.exists(idx) ? occ_hits[idx] : 0;
				fre = free_hits.exists(idx) ? free_hits[idx] : 0;
				den = occ + fre;
				if (den > 0) begin
					diff = (fre > occ) ? fre - occ : occ - fre;
					q = (2 * 1735 * diff + den) / (2 * den);
					lo = lo + ((fre > occ) ? -q : q);
					if (lo > 10240) lo = 10240;
					if (lo < -10240) lo = -10240;
					cell_lo[idx] = shortint'(lo);
				end
				occ_hits.delete(idx);
				free_hits.delete(idx);
				o.in_bounds = 1'b1;
				if (lo > 1735) o.cell_class = CLASS_OCC;
				else if (lo < -1735) o.cell_class = CLASS_FREE;
			end
		end
		return o;
	endfunction

	task automatic queue_req(input req_t r);
		res_t e;
		e = update_grid(r);
		if (e.in_bounds && r.cmd != CMD_COMMIT)
			hot_cells.insert(hot_cells.size(), int'(e.cell_index));
		if (r.cmd == CMD_COMMIT) n_commits++;
		if (e.in_bounds) n_inb++;
		expected_res.insert(expected_res.size(), e);
		pending_reqs.insert(pending_reqs.size(), r);
		n_queued++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			CFG_POSE_X:  pose_x = longint'($signed(v));
			CFG_POSE_Y:  pose_y = longint'($signed(v));
			CFG_SIN:     sin_q = longint'($signed(v[15:0]));
			CFG_COS:     cos_q = longint'($signed(v[15:0]));
			CFG_INV_RES: inv_q = longint'(v[15:0]);
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [23:0] px, input logic [23:0] py,
			input logic [15:0] s, input logic [15:0] c, input logic [15:0] inv);
		write_reg(CFG_POSE_X, px);
		write_reg(CFG_POSE_Y, py);
		write_reg(CFG_SIN, {8'h00, s});
		write_reg(CFG_COS, {8'h00, c});
		write_reg(CFG_INV_RES, {8'h00, inv});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold until every request is taken and answered, then let the pipe settle
	task automatic drain_grid();
		while (n_taken != n_queued || expected_res.size() != 0 || req_valid)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic req_t point_req(input logic [1:0] cmd,
			input logic signed [15:0] lat, input logic signed [15:0] fwd);
		req_t r;
		r = '0;
		r.cmd = cmd;
		r.point_lateral_mm = lat;
		r.point_forward_mm = fwd;
		r.commit_cell = 20'($urandom);
		return r;
	endfunction

	function automatic req_t commit_req(input logic [19:0] cell_id);
		req_t r;
		r = '0;
		r.cmd = CMD_COMMIT;
		r.commit_cell = cell_id;
		r.point_lateral_mm = 16'($urandom);
		r.point_forward_mm = 16'($urandom);
		return r;
	endfunction

	function automatic point_t pick_point();
		point_t p;
		int     span, k;
		k = $urandom_range(9);
		if (k < 2 || inv_q == 0) begin
			p.lat = 16'($urandom);
			p.fwd = 16'($urandom);
		end else if (k < 6 && seen_points.size() > 0) begin
			p = seen_points[$urandom_range(seen_points.size() - 1)];
		end else begin
			span = int'((longint'(400) * 65536) / inv_q);
			if (span > 32767) span = 32767;
			if (span < 1) span = 1;
			p.lat = 16'($urandom_range(2 * span) - span);
			p.fwd = 16'($urandom_range(2 * span) - span);
			seen_points.insert(seen_points.size(), p);
			if (seen_points.size() > 24) void'(seen_points.pop_front());
		end
		return p;
	endfunction

	task automatic random_reqs(input int count);
		int     k, j, n;
		point_t p;
		req_t   r;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(99);
			if (k < 55) begin
				p = pick_point();
				queue_req(point_req($urandom_range(1) ? CMD_OCC : CMD_FREE, p.lat, p.fwd));
			end else if (k < 85) begin
				if (hot_cells.size() > 0)
					queue_req(commit_req(20'(hot_cells[$urandom_range(hot_cells.size() - 1)])));
				else
					queue_req(commit_req(20'($urandom)));
			end else if (k < 91) begin
				queue_req(commit_req(20'($urandom)));
			end else if (k < 95) begin
				r = point_req(2'd3, 16'($urandom), 16'($urandom));
				queue_req(r);
			end else begin
				p = pick_point();
				n = $urandom_range(5, 20);
				for (j = 0; j < n; j++)
					queue_req(point_req($urandom_range(3) != 0 ? CMD_OCC : CMD_FREE,
						p.lat, p.fwd));
				i += n - 1;
			end
			if (hot_cells.size() > 64) void'(hot_cells.pop_front());
		end
	endtask

	// request driver
	always @(posedge clk) begin : drive_req
		int gap;
		if (req_valid && req_ready) n_taken++;
		if (!(req_valid && !req_ready)) begin
			if (gap > 0) begin
				gap--;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
				if (quiet || $urandom_range(2) != 0) gap = 0;
				else if ($urandom_range(19) == 0) gap = $urandom_range(15, 40);
				else gap = $urandom_range(1, 3);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin : watch_res
		int   stall;
		int   hold_left;
		res_t e;
		if (res_valid && res_ready) begin
			if (expected_res.size() == 0) begin
				$error("unexpected result: cell_index %0d", res.cell_index);
				n_err++;
			end else begin
				e = expected_res.pop_front();
				n_checked++;
				if (res.cell_index !== e.cell_index) begin
					$error("cell_index: expected %0d, got %0d", e.cell_index, res.cell_index);
					n_err++;
				end
				if (res.in_bounds !== e.in_bounds) begin
					$error("in_bounds: expected %0d, got %0d", e.in_bounds, res.in_bounds);
					n_err++;
				end
				if (res.cell_class !== e.cell_class) begin
					$error("cell_class: expected %0d, got %0d", e.cell_class, res.cell_class);
					n_err++;
				end
			end
		end
		if (hold_req && hold_left == 0 && stall >= 0) begin
			hold_left = 300;
			stall = -1;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else if (stall > 0) begin
			stall--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
			if (!quiet && $urandom_range(5) == 0) begin
				if ($urandom_range(11) == 0) stall = $urandom_range(20, 60);
				else stall = $urandom_range(1, 3);
			end else begin
				stall = 0;
			end
		end
	end

	initial begin
		point_t p;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: center, extremes, no-hit commit, top index, command three
		queue_req(point_req(CMD_FREE, 16'sd0, 16'sd0));
		queue_req(point_req(CMD_OCC, 16'sd0, 16'sd0));
		queue_req(point_req(CMD_OCC, 16'sd0, 16'sd0));
		queue_req(commit_req(20'(CENTER)));
		queue_req(commit_req(20'(CENTER)));
		queue_req(point_req(CMD_OCC, 16'sh7fff, 16'sh7fff));
		queue_req(point_req(CMD_FREE, -16'sh8000, -16'sh8000));
		queue_req(point_req(CMD_FREE, 16'sh7fff, -16'sh8000));
		queue_req(point_req(CMD_OCC, 16'sd30, 16'sd20000));
		queue_req(point_req(CMD_FREE, -16'sd30, -16'sd20000));
		queue_req(commit_req(20'd5));
		queue_req(commit_req(20'd0));
		queue_req(commit_req(20'hfffff));
		queue_req(point_req(2'd3, 16'shffff, 16'shffff));
		queue_req(point_req(2'd3, 16'sd0, 16'sd0));
		for (int i = 0; i < 4; i++) queue_req(point_req(CMD_FREE, 16'sd100, 16'sd60));
		queue_req(commit_req(20'(hot_cells[$])));
		random_reqs(90);
		drain_grid();

		// receiver holds off while requests keep coming
		hold_req = 1;
		random_reqs(60);
		repeat (5) @(posedge clk);
		hold_req = 0;
		drain_grid();

		// quarter turn, plus count saturation on one cell
		write_all(24'd0, 24'd0, 16'sd16384, 16'sd0, 16'd1092);
		quiet = 1;
		for (int i = 0; i < 270; i++) queue_req(point_req(CMD_OCC, 16'sd600, -16'sd300));
		queue_req(commit_req(20'(hot_cells[$])));
		drain_grid();
		quiet = 0;
		random_reqs(60);
		drain_grid();

		// extremes of every register
		write_all(24'h7fffff, 24'h800000, -16'sd16384, -16'sd16384, 16'hffff);
		random_reqs(60);
		drain_grid();
		write_all(24'h800000, 24'h7fffff, 16'sd16384, 16'sd16384, 16'd1);
		random_reqs(60);
		drain_grid();

		// zero scale folds every point onto the center
		write_all(24'($urandom), 24'($urandom), 16'sd11585, -16'sd11585, 16'd0);
		random_reqs(50);
		drain_grid();

		// modest offsets and yaw, no idling for a stretch
		write_all(24'($urandom_range(4000)) - 24'd2000, 24'($urandom_range(4000)) - 24'd2000,
			16'sd6270, 16'sd15137, 16'd2184);
		quiet = 1;
		random_reqs(50);
		drain_grid();
		quiet = 0;
		random_reqs(60);
		drain_grid();

		$display("%0d requests checked, %0d commits, %0d landed on the grid or a valid cell",
			n_checked, n_commits, n_inb);
		$display("covered 6 register settings incl. extremes, zero scale and count saturation");
		if (n_err == 0) begin
			$display("log_odds_occupancy_grid_update_top_test: clean");
		end else begin
			$display("log_odds_occupancy_grid_update_top_test: errors");
		end
		$finish;
	end

	// timeout: the clearing pass after reset alone sweeps all 1024x1024 cells
	initial begin
		#50_000_000;
		$display("log_odds_occupancy_grid_update_top_test: errors");
		$finish;
	end

endmodule

`default_nettype wire
